[src/fbc_pkg.sv]
package fbc_pkg;

    localparam int PLANE_REGS  = 4;
    localparam int AXES        = 3;
    localparam int COORD_W     = 24;
    localparam int NORMAL_W    = 16;
    localparam int PRODUCT_W   = COORD_W + NORMAL_W;
    localparam int DIST_W      = 32;
    localparam int DIST_SHIFT  = 13;
    localparam int ACC_W       = DIST_W + DIST_SHIFT + 1;
    localparam int COUNT_W     = 32;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = NORMAL_W * AXES;
    localparam int PLANE_IDX_W = $clog2(PLANE_REGS);

    localparam logic [CFG_INDEX_W-1:0] CFG_NORMAL_BASE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_DIST_BASE   = CFG_INDEX_W'(PLANE_REGS);
    localparam logic [CFG_INDEX_W-1:0] CFG_REG_END     = CFG_INDEX_W'(2 * PLANE_REGS);

    typedef logic signed [COORD_W-1:0]   coord_t;
    typedef coord_t [AXES-1:0]            coord_vec_t;
    typedef logic signed [NORMAL_W-1:0]  normal_t;
    typedef logic [CFG_DATA_W-1:0]       plane_normal_t;
    typedef logic signed [DIST_W-1:0]    dist_t;
    typedef logic signed [PRODUCT_W-1:0] product_t;
    typedef logic signed [ACC_W-1:0]     acc_t;
    typedef logic [COUNT_W-1:0]          count_t;
    typedef logic [CFG_INDEX_W-1:0]      cfg_index_t;

    typedef struct packed {
        logic load_b;
        logic load_c;
    } stage_ctrl_t;

endpackage

[src/frustum_box_cull_unit.sv]
// channel  | signals                                         | transfer
// box      | box_valid, box_ready, min_x..max_z              | box_valid && box_ready
// result   | result_valid, result_ready, visible, *_total    | result_valid && result_ready
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data       | cfg_valid && cfg_ready
//
// One box per cycle unless a stalled result backs the stages up; each box passes
// through the bounds, product, plane test and result registers before it is offered.
// Reset clears the stage valids, the counters and the plane registers to zero.
// Each stage holds only while the one after it is full and stalled; bubbles collapse.
module frustum_box_cull_unit
    import fbc_pkg::*;
#(
    parameter int NUM_PLANES = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       box_valid,
    output logic       box_ready,
    input  coord_t     min_x,
    input  coord_t     min_y,
    input  coord_t     min_z,
    input  coord_t     max_x,
    input  coord_t     max_y,
    input  coord_t     max_z,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       visible,
    output count_t     accepted_total,
    output count_t     rejected_total,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LANES = (NUM_PLANES < PLANE_REGS) ? NUM_PLANES : PLANE_REGS;

    plane_normal_t [PLANE_REGS-1:0] normals;
    dist_t [PLANE_REGS-1:0]         distances;
    coord_vec_t                     box_lo;
    coord_vec_t                     box_hi;
    logic [LANES-1:0]               front;
    stage_ctrl_t                    ctrl;

    logic   valid_a_reg, valid_b_reg, valid_c_reg, valid_d_reg;
    logic   free_a, free_b, free_c, free_d;
    logic   load_d;
    logic   visible_reg;
    count_t accept_cnt_reg, accept_cnt_next;
    count_t reject_cnt_reg, reject_cnt_next;

    assign free_d = !valid_d_reg || result_ready;
    assign free_c = !valid_c_reg || free_d;
    assign free_b = !valid_b_reg || free_c;
    assign free_a = !valid_a_reg || free_b;
    assign load_d = free_d && valid_c_reg;

    assign ctrl = '{load_b: free_b, load_c: free_c};

    assign box_ready = free_a;
    assign cfg_ready = 1'b1;

    fbc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .normals   (normals),
        .distances (distances)
    );

    fbc_box_bounds u_bounds (
        .clk    (clk),
        .load   (box_valid && free_a),
        .min_x  (min_x),
        .min_y  (min_y),
        .min_z  (min_z),
        .max_x  (max_x),
        .max_y  (max_y),
        .max_z  (max_z),
        .box_lo (box_lo),
        .box_hi (box_hi)
    );

    for (genvar p = 0; p < LANES; p++)
    begin : g_lane
        fbc_plane_lane u_lane (
            .clk      (clk),
            .ctrl     (ctrl),
            .normal   (normals[p]),
            .distance (distances[p]),
            .box_lo   (box_lo),
            .box_hi   (box_hi),
            .front    (front[p])
        );
    end

    always_comb
    begin
        accept_cnt_next = accept_cnt_reg;
        reject_cnt_next = reject_cnt_reg;
        if (&front)
        begin
            accept_cnt_next = accept_cnt_reg + COUNT_W'(1);
        end
        else
        begin
            reject_cnt_next = reject_cnt_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg    <= 1'b0;
            valid_b_reg    <= 1'b0;
            valid_c_reg    <= 1'b0;
            valid_d_reg    <= 1'b0;
            accept_cnt_reg <= '0;
            reject_cnt_reg <= '0;
        end
        else
        begin
            if (free_a)
            begin
                valid_a_reg <= box_valid;
            end
            if (free_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
            if (free_c)
            begin
                valid_c_reg <= valid_b_reg;
            end
            if (free_d)
            begin
                valid_d_reg <= valid_c_reg;
            end
            if (load_d)
            begin
                accept_cnt_reg <= accept_cnt_next;
                reject_cnt_reg <= reject_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_d)
        begin
            visible_reg <= &front;
        end
    end

    assign result_valid   = valid_d_reg;
    assign visible        = visible_reg;
    assign accepted_total = accept_cnt_reg;
    assign rejected_total = reject_cnt_reg;

endmodule

[src/fbc_cfg_regs.sv]
module fbc_cfg_regs
    import fbc_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  cfg_index_t                      cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_data,
    output plane_normal_t [PLANE_REGS-1:0]  normals,
    output dist_t [PLANE_REGS-1:0]          distances
);

    plane_normal_t [PLANE_REGS-1:0] normal_reg;
    dist_t [PLANE_REGS-1:0]         dist_reg;
    logic [PLANE_IDX_W-1:0]         slot;

    assign slot = cfg_index[PLANE_IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg <= '0;
            dist_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index inside {[CFG_NORMAL_BASE:CFG_DIST_BASE-1]})
            begin
                normal_reg[slot] <= cfg_data;
            end
            else if (cfg_index inside {[CFG_DIST_BASE:CFG_REG_END-1]})
            begin
                dist_reg[slot] <= dist_t'(cfg_data[DIST_W-1:0]);
            end
        end
    end

    assign normals   = normal_reg;
    assign distances = dist_reg;

endmodule

[src/fbc_box_bounds.sv]
module fbc_box_bounds
    import fbc_pkg::*;
(
    input  logic       clk,
    input  logic       load,
    input  coord_t     min_x,
    input  coord_t     min_y,
    input  coord_t     min_z,
    input  coord_t     max_x,
    input  coord_t     max_y,
    input  coord_t     max_z,
    output coord_vec_t box_lo,
    output coord_vec_t box_hi
);

    coord_vec_t lo_in;
    coord_vec_t hi_in;
    coord_vec_t lo_next;
    coord_vec_t hi_next;
    coord_vec_t lo_reg;
    coord_vec_t hi_reg;

    assign lo_in = {min_z, min_y, min_x};
    assign hi_in = {max_z, max_y, max_x};

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            if ($signed(lo_in[a]) < $signed(hi_in[a]))
            begin
                lo_next[a] = lo_in[a];
                hi_next[a] = hi_in[a];
            end
            else
            begin
                lo_next[a] = hi_in[a];
                hi_next[a] = lo_in[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign box_lo = lo_reg;
    assign box_hi = hi_reg;

endmodule

[src/fbc_plane_lane.sv]
module fbc_plane_lane
    import fbc_pkg::*;
(
    input  logic          clk,
    input  stage_ctrl_t   ctrl,
    input  plane_normal_t normal,
    input  dist_t         distance,
    input  coord_vec_t    box_lo,
    input  coord_vec_t    box_hi,
    output logic          front
);

    product_t product_next [AXES];
    product_t product_reg  [AXES];
    acc_t     dot_sum;
    acc_t     dist_scaled;
    logic     front_next;
    logic     front_reg;

    // pick the corner coordinate that maximises each term of the dot product
    always_comb
    begin
        normal_t n;
        coord_t  c;
        for (int a = 0; a < AXES; a++)
        begin
            n = normal_t'(normal[a*NORMAL_W +: NORMAL_W]);
            c = n[NORMAL_W-1] ? box_lo[a] : box_hi[a];
            product_next[a] = product_t'(n) * product_t'(c);
        end
    end

    always_comb
    begin
        dot_sum = '0;
        for (int a = 0; a < AXES; a++)
        begin
            dot_sum = dot_sum + acc_t'(product_reg[a]);
        end
        dist_scaled = acc_t'(distance) <<< DIST_SHIFT;
        front_next  = (dot_sum >= dist_scaled);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_b)
        begin
            product_reg <= product_next;
        end
        if (ctrl.load_c)
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

[src/fbc_checker.sv]
module fbc_checker
    import fbc_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   box_valid,
    input logic   box_ready,
    input logic   result_valid,
    input logic   result_ready,
    input logic   visible,
    input count_t accepted_total,
    input count_t rejected_total
);

    logic       box_xfer;
    logic       result_xfer;
    logic [2:0] pending_reg;
    count_t     last_acc_reg;
    count_t     last_rej_reg;

    assign box_xfer    = box_valid && box_ready;
    assign result_xfer = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            last_acc_reg <= '0;
            last_rej_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(box_xfer) - 3'(result_xfer);
            if (result_xfer)
            begin
                last_acc_reg <= accepted_total;
                last_rej_reg <= rejected_total;
            end
        end
    end

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_xfer |->
            (visible && accepted_total == last_acc_reg + COUNT_W'(1)
                     && rejected_total == last_rej_reg)
         || (!visible && rejected_total == last_rej_reg + COUNT_W'(1)
                      && accepted_total == last_acc_reg))
        else $error("running totals do not follow the visible flag");

    a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more boxes in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 3'd0)
        else $error("result shown with no box in flight");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(visible) && $stable(accepted_total)
            && $stable(rejected_total))
        else $error("stalled result changed");

endmodule

bind frustum_box_cull_unit fbc_checker u_fbc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .box_valid      (box_valid),
    .box_ready      (box_ready),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .visible        (visible),
    .accepted_total (accepted_total),
    .rejected_total (rejected_total)
);

[tb/tb_frustum_box_cull_unit.sv]
module tb_frustum_box_cull_unit
    import fbc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PLANES    = 4;
    localparam int RIGHT_PLANE   = 0;
    localparam int LEFT_PLANE    = 1;
    localparam int TOP_PLANE     = 2;
    localparam int BOTTOM_PLANE  = 3;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BOXES   = 240;
    localparam int DIRECTED_ROWS = 20;

    localparam coord_t CMIN = coord_t'(24'h800000);
    localparam coord_t CMAX = coord_t'(24'h7FFFFF);

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } box_t;

    typedef struct packed {
        logic   visible;
        count_t accepted;
        count_t rejected;
    } verdict_t;

    typedef struct packed {
        logic [1:0] setting;
        box_t       box;
        logic       typed;
        logic       visible;
        count_t     accepted;
        count_t     rejected;
    } box_row_t;

    // setting 0: planes at reset, 1: right plane rejects all, 2: all planes pass all,
    // 3: a 90 degree frustum looking down +z
    localparam box_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{2'd0, '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, 1'b1, 1'b1, 32'd1, 32'd0},
        '{2'd0, '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, 1'b1, 1'b1, 32'd2, 32'd0},
        '{2'd0, '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1, 1'b1, 32'd3, 32'd0},
        '{2'd0, '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1'b1, 1'b1, 32'd4, 32'd0},
        '{2'd0, '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}, 1'b1, 1'b1, 32'd5, 32'd0},
        '{2'd0, '{CMIN, 24'sd0, CMAX, CMAX, -24'sd1, CMIN}, 1'b1, 1'b1, 32'd6, 32'd0},
        '{2'd1, '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, 1'b1, 1'b0, 32'd6, 32'd1},
        '{2'd1, '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1'b1, 1'b0, 32'd6, 32'd2},
        '{2'd1, '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, 1'b1, 1'b0, 32'd6, 32'd3},
        '{2'd2, '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, 1'b1, 1'b1, 32'd7, 32'd3},
        '{2'd2, '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN}, 1'b1, 1'b1, 32'd8, 32'd3},
        '{2'd3, '{-24'sd256, -24'sd256, 24'sd2304, 24'sd256, 24'sd256, 24'sd2816},
            1'b0, 1'b0, 32'd0, 32'd0},
        '{2'd3, '{24'sd5120, -24'sd256, 24'sd1280, 24'sd7680, 24'sd256, 24'sd1536},
            1'b0, 1'b0, 32'd0, 32'd0},
        '{2'd3, '{-24'sd7680, -24'sd256, 24'sd1280, -24'sd5120, 24'sd256, 24'sd1536},
            1'b0, 1'b0, 32'd0, 32'd0},
        '{2'd3, '{-24'sd256, 24'sd5120, 24'sd1280, 24'sd256, 24'sd7680, 24'sd1536},
            1'b0, 1'b0, 32'd0, 32'd0},
        '{2'd3, '{-24'sd256, -24'sd7680, 24'sd1280, 24'sd256, -24'sd5120, 24'sd1536},
            1'b0, 1'b0, 32'd0, 32'd0},
        '{2'd3, '{24'sd1024, -24'sd256, 24'sd768, 24'sd3072, 24'sd256, 24'sd1024},
            1'b0, 1'b0, 32'd0, 32'd0},
        '{2'd3, '{-24'sd256, -24'sd256, -24'sd2560, 24'sd256, 24'sd256, -24'sd2304},
            1'b0, 1'b0, 32'd0, 32'd0},
        '{2'd3, '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, 1'b0, 1'b0, 32'd0, 32'd0},
        '{2'd3, '{24'sd7680, 24'sd256, 24'sd1536, 24'sd5120, -24'sd256, 24'sd1280},
            1'b0, 1'b0, 32'd0, 32'd0}
    };

    logic       clk;
    logic       rst_n;
    logic       box_valid;
    logic       box_ready;
    coord_t     min_x;
    coord_t     min_y;
    coord_t     min_z;
    coord_t     max_x;
    coord_t     max_y;
    coord_t     max_z;
    logic       result_valid;
    logic       result_ready;
    logic       visible;
    count_t     accepted_total;
    count_t     rejected_total;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    plane_normal_t plane_normal [PLANE_REGS];
    dist_t         plane_offset [PLANE_REGS];
    count_t        accept_count;
    count_t        reject_count;
    verdict_t      pending_verdicts [$];

    int mismatches;
    int boxes_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;

    frustum_box_cull_unit #(
        .NUM_PLANES(NUM_PLANES)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .box_valid      (box_valid),
        .box_ready      (box_ready),
        .min_x          (min_x),
        .min_y          (min_y),
        .min_z          (min_z),
        .max_x          (max_x),
        .max_y          (max_y),
        .max_z          (max_z),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .visible        (visible),
        .accepted_total (accepted_total),
        .rejected_total (rejected_total),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic corner_clears_plane(int p, longint cx, longint cy, longint cz);
        normal_t nx;
        normal_t ny;
        normal_t nz;
        longint  dot;
        longint  bar;
        nx  = plane_normal[p][15:0];
        ny  = plane_normal[p][31:16];
        nz  = plane_normal[p][47:32];
        dot = cx * longint'(nx) + cy * longint'(ny) + cz * longint'(nz);
        bar = longint'(plane_offset[p]) <<< DIST_SHIFT;
        return (dot - bar) >= 0;
    endfunction

    function automatic logic box_in_view(box_t b);
        longint lo [3];
        longint hi [3];
        logic   any_front;
        logic   seen;
        int     planes;
        seen   = 1'b1;
        planes = (NUM_PLANES < PLANE_REGS) ? NUM_PLANES : PLANE_REGS;
        lo[0]  = b.min_x;
        lo[1]  = b.min_y;
        lo[2]  = b.min_z;
        hi[0]  = b.max_x;
        hi[1]  = b.max_y;
        hi[2]  = b.max_z;
        for (int p = 0; p < planes; p++)
        begin
            any_front = 1'b0;
            for (int k = 0; k < 8; k++)
            begin
                if (corner_clears_plane(p, k[0] ? hi[0] : lo[0], k[1] ? hi[1] : lo[1],
                                        k[2] ? hi[2] : lo[2]))
                    any_front = 1'b1;
            end
            if (!any_front)
                seen = 1'b0;
        end
        return seen;
    endfunction

    function automatic verdict_t predict_verdict(box_t b);
        verdict_t v;
        v.visible = box_in_view(b);
        if (v.visible)
            accept_count = accept_count + 1;
        else
            reject_count = reject_count + 1;
        v.accepted = accept_count;
        v.rejected = reject_count;
        return v;
    endfunction

    function automatic normal_t pick_component(logic extreme);
        if (!extreme)
            return normal_t'($urandom);
        case ($urandom_range(3))
            0:       return normal_t'(16'h8000);
            1:       return normal_t'(16'h7FFF);
            2:       return normal_t'(16'hFFFF);
            default: return normal_t'(16'h0000);
        endcase
    endfunction

    function automatic box_t random_box();
        box_t b;
        int   roll;
        int   centre;
        int   half;
        int   lo [3];
        int   hi [3];
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            b.min_x = coord_t'($urandom);
            b.min_y = coord_t'($urandom);
            b.min_z = coord_t'($urandom);
            b.max_x = coord_t'($urandom);
            b.max_y = coord_t'($urandom);
            b.max_z = coord_t'($urandom);
            return b;
        end
        for (int a = 0; a < 3; a++)
        begin
            centre = int'($urandom_range(0, 32'h800000)) - 32'h400000;
            half   = int'($urandom_range(0, 1 << $urandom_range(2, 20)));
            lo[a]  = centre - half;
            hi[a]  = centre + half;
        end
        // swap the corners now and then: min above max
        if (roll < 20)
        begin
            b = '{coord_t'(hi[0]), coord_t'(hi[1]), coord_t'(hi[2]),
                  coord_t'(lo[0]), coord_t'(lo[1]), coord_t'(lo[2])};
        end
        else
        begin
            b = '{coord_t'(lo[0]), coord_t'(lo[1]), coord_t'(lo[2]),
                  coord_t'(hi[0]), coord_t'(hi[1]), coord_t'(hi[2])};
        end
        return b;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < CFG_DIST_BASE)
            plane_normal[idx - CFG_NORMAL_BASE] = data;
        else if (idx < CFG_REG_END)
            plane_offset[idx - CFG_DIST_BASE] = data[DIST_W-1:0];
        @(negedge clk);
    endtask

    task automatic load_planes(input plane_normal_t [PLANE_REGS-1:0] normals,
                               input dist_t [PLANE_REGS-1:0] offsets);
        for (int p = 0; p < PLANE_REGS; p++)
            write_reg(cfg_index_t'(CFG_NORMAL_BASE + p), normals[p]);
        for (int p = 0; p < PLANE_REGS; p++)
            write_reg(cfg_index_t'(CFG_DIST_BASE + p), {16'($urandom), offsets[p]});
    endtask

    task automatic apply_directed_setting(input logic [1:0] setting);
        plane_normal_t [PLANE_REGS-1:0] normals;
        dist_t [PLANE_REGS-1:0]         offsets;
        normals = '0;
        offsets = '0;
        case (setting)
            2'd1:
            begin
                normals[RIGHT_PLANE] = 48'h8000_8000_8000;
                offsets[RIGHT_PLANE] = dist_t'(32'h7FFF_FFFF);
            end
            2'd2:
            begin
                for (int p = 0; p < PLANE_REGS; p++)
                begin
                    normals[p] = 48'h7FFF_7FFF_7FFF;
                    offsets[p] = dist_t'(32'h8000_0000);
                end
            end
            default:
            begin
                normals[RIGHT_PLANE]  = {16'sd5793, 16'sd0, -16'sd5793};
                normals[LEFT_PLANE]   = {16'sd5793, 16'sd0, 16'sd5793};
                normals[TOP_PLANE]    = {16'sd5793, -16'sd5793, 16'sd0};
                normals[BOTTOM_PLANE] = {16'sd5793, 16'sd5793, 16'sd0};
                offsets[RIGHT_PLANE]  = -32'sd256;
                offsets[LEFT_PLANE]   = -32'sd256;
                offsets[TOP_PLANE]    = -32'sd512;
                offsets[BOTTOM_PLANE] = 32'sd0;
            end
        endcase
        load_planes(normals, offsets);
        // indexes past the last register must leave the planes alone
        if (setting == 2'd3)
        begin
            for (int idx = int'(CFG_REG_END); idx < (1 << CFG_INDEX_W); idx++)
                write_reg(cfg_index_t'(idx), '1);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic load_random_planes(input logic extreme);
        plane_normal_t [PLANE_REGS-1:0] normals;
        dist_t [PLANE_REGS-1:0]         offsets;
        for (int p = 0; p < PLANE_REGS; p++)
        begin
            normals[p] = {pick_component(extreme), pick_component(extreme),
                          pick_component(extreme)};
            case ($urandom_range(7))
                0, 1, 2: offsets[p] = dist_t'(32'h8000_0000);
                3:       offsets[p] = extreme ? dist_t'(32'h7FFF_FFFF) : dist_t'($urandom);
                default: offsets[p] = dist_t'(int'($urandom_range(0, 32'h800000)) - 32'h400000);
            endcase
        end
        load_planes(normals, offsets);
        cfg_valid <= 1'b0;
    endtask

    task automatic offer_box(input box_t b, input logic typed, input verdict_t typed_verdict);
        verdict_t v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            box_valid <= 1'b0;
            @(negedge clk);
        end
        box_valid <= 1'b1;
        min_x     <= b.min_x;
        min_y     <= b.min_y;
        min_z     <= b.min_z;
        max_x     <= b.max_x;
        max_y     <= b.max_y;
        max_z     <= b.max_z;
        @(posedge clk);
        while (!box_ready)
            @(posedge clk);
        v = predict_verdict(b);
        pending_verdicts.push_back(typed ? typed_verdict : v);
        boxes_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        box_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver: random stalls, plus long hold-offs while the sender keeps offering
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_done < 2 && boxes_sent >= 400 + 800 * holds_done)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch("transfer with nothing pending, visible", 32'(visible), 32'd0);
            else
            begin
                want = pending_verdicts.pop_front();
                if (visible !== want.visible)
                    report_mismatch("visible", 32'(visible), 32'(want.visible));
                if (accepted_total !== want.accepted)
                    report_mismatch("accepted_total", accepted_total, want.accepted);
                if (rejected_total !== want.rejected)
                    report_mismatch("rejected_total", rejected_total, want.rejected);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[frustum_box_cull_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [1:0] current;
        box_row_t   row;
        clk           = 1'b0;
        rst_n         = 1'b0;
        box_valid     = 1'b0;
        min_x         = '0;
        min_y         = '0;
        min_z         = '0;
        max_x         = '0;
        max_y         = '0;
        max_z         = '0;
        result_ready  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        mismatches    = 0;
        boxes_sent    = 0;
        cycle_count   = 0;
        accept_count  = '0;
        reject_count  = '0;
        send_idle_pct = 19;
        recv_idle_pct = 54;
        for (int p = 0; p < PLANE_REGS; p++)
        begin
            plane_normal[p] = '0;
            plane_offset[p] = '0;
        end

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        current = 2'd0;
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.setting != current)
            begin
                settle();
                apply_directed_setting(row.setting);
                current = row.setting;
            end
            offer_box(row.box, row.typed, '{row.visible, row.accepted, row.rejected});
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            if (phase == 3)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 19;
            end
            else if (phase == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_random_planes(phase == 0 || phase == 5);
            for (int n = 0; n < PHASE_BOXES; n++)
                offer_box(random_box(), 1'b0, '0);
        end
        settle();

        if (mismatches == 0)
            $display("[frustum_box_cull_unit] OK");
        else
            $display("[frustum_box_cull_unit] ERROR");
        $finish;
    end

endmodule
